// ===== rtl/ogc_pkg.sv =====
package ogc_pkg;

  typedef logic signed [27:0] q_t;
  typedef logic signed [29:0] mop_t;
  typedef logic signed [37:0] wide_t;

  localparam wide_t Q_ONE  = 38'sd16777216;
  localparam wide_t Q_HALF = 38'sd8388608;
  localparam wide_t Q_MAX  = 38'sd134217727;
  localparam wide_t Q_MIN  = -38'sd134217728;
  localparam wide_t OFFS   = 38'sd922747;

  localparam mop_t HALFPI = 30'sd26353589;
  localparam mop_t SLOPE  = 30'sd216761631;
  localparam mop_t GAIN   = 30'sd17699963;

  localparam logic [24:0] KNEE = 25'd52526;

  localparam logic [3:0] SIN_LAST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd10;

  function automatic q_t sat_q(wide_t v);
    if (v > Q_MAX) begin
      return q_t'(Q_MAX);
    end else if (v < Q_MIN) begin
      return q_t'(Q_MIN);
    end
    return q_t'(v);
  endfunction

  // series divisor reciprocals, sine terms first then cosine terms
  // exact for dividends below 2^27
  function automatic mop_t ser_rcp(logic [3:0] i);
    mop_t m;
    unique case (i)
      4'd0:    m = mop_t'(((64'd1 << 34) + 64'd109) / 64'd110);
      4'd1:    m = mop_t'(((64'd1 << 34) + 64'd71) / 64'd72);
      4'd2:    m = mop_t'(((64'd1 << 33) + 64'd41) / 64'd42);
      4'd3:    m = mop_t'(((64'd1 << 32) + 64'd19) / 64'd20);
      4'd4:    m = mop_t'(((64'd1 << 30) + 64'd5) / 64'd6);
      4'd5:    m = mop_t'(((64'd1 << 35) + 64'd131) / 64'd132);
      4'd6:    m = mop_t'(((64'd1 << 34) + 64'd89) / 64'd90);
      4'd7:    m = mop_t'(((64'd1 << 33) + 64'd55) / 64'd56);
      4'd8:    m = mop_t'(((64'd1 << 32) + 64'd29) / 64'd30);
      4'd9:    m = mop_t'(((64'd1 << 31) + 64'd11) / 64'd12);
      4'd10:   m = mop_t'(((64'd1 << 28) + 64'd1) / 64'd2);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] ser_sh(logic [3:0] i);
    logic [5:0] s;
    unique case (i)
      4'd0:    s = 6'd34;
      4'd1:    s = 6'd34;
      4'd2:    s = 6'd33;
      4'd3:    s = 6'd32;
      4'd4:    s = 6'd30;
      4'd5:    s = 6'd35;
      4'd6:    s = 6'd34;
      4'd7:    s = 6'd33;
      4'd8:    s = 6'd32;
      4'd9:    s = 6'd31;
      4'd10:   s = 6'd28;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic mop_t lab_coef(logic [1:0] row, logic col);
    mop_t c;
    unique case ({row, col})
      3'b000:  c = 30'sd6649445;
      3'b001:  c = 30'sd3620586;
      3'b010:  c = -30'sd1771026;
      3'b011:  c = -30'sd1071295;
      3'b100:  c = -30'sd1501295;
      3'b101:  c = -30'sd21667532;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic mop_t rgb_coef(logic [1:0] row, logic [1:0] col);
    mop_t c;
    unique case ({row, col})
      4'b0000: c = 30'sd68396375;
      4'b0001: c = -30'sd55494192;
      4'b0010: c = 30'sd3875032;
      4'b0100: c = -30'sd21280858;
      4'b0101: c = 30'sd43784464;
      4'b0110: c = -30'sd5726389;
      4'b1000: c = -30'sd70399;
      4'b1001: c = -30'sd11801406;
      4'b1010: c = 30'sd28649021;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ogc_in_if.sv =====
interface ogc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] lightness;
  logic [15:0] chroma;
  logic [15:0] hue;

  modport source (output valid, output lightness, output chroma, output hue, input ready);
  modport sink (input valid, input lightness, input chroma, input hue, output ready);
endinterface

// ===== rtl/ogc_out_if.sv =====
interface ogc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] chroma_used;
  logic        was_clipped;

  modport source (output valid, output red, output green, output blue,
                  output chroma_used, output was_clipped, input ready);
  modport sink (input valid, input red, input green, input blue,
                input chroma_used, input was_clipped, output ready);
endinterface

// ===== rtl/oklch_gamut_clip_to_srgb_top.sv =====
// OKLCH to sRGB converter with hue-preserving chroma clipping.
// in_if carries one colour (lightness, chroma, hue) per transfer; out_if
// returns one result per input: red, green, blue, chroma_used, was_clipped.
// Both channels transfer when valid and ready are high at a clock edge.
// The APB port holds the gamut tolerance register at address 0.
// One colour is worked on at a time; in_if.ready is high only while idle.
// Hue to sine and cosine runs a series with a reciprocal multiply for
// each division; a clipped colour takes up to SEARCH_STEPS + 4 gamut
// tests, and each bright channel runs square and cube root iterations.
// Everything goes through the one shared multiplier.
// The result sits in an output register; a stalled receiver holds the
// block in its last step until the register frees, and a new colour is
// taken as soon as the result has moved into it.
// Reset clears the sequencer, the output valid and the tolerance to zero.
module oklch_gamut_clip_to_srgb_top #(
  parameter int SEARCH_STEPS = 24,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ogc_in_if.sink      in_if,
  ogc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STEP_W = $clog2(SEARCH_STEPS + 1);
  localparam logic [16:0] CHAN_MAX = 17'((1 << CHANNEL_BITS) - 1);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_SX0   = 6'd1;
  localparam logic [5:0] S_SX1   = 6'd2;
  localparam logic [5:0] S_SX2   = 6'd3;
  localparam logic [5:0] S_SX3   = 6'd4;
  localparam logic [5:0] S_SER0  = 6'd5;
  localparam logic [5:0] S_SER1  = 6'd6;
  localparam logic [5:0] S_DIV   = 6'd7;
  localparam logic [5:0] S_SIN0  = 6'd8;
  localparam logic [5:0] S_SIN1  = 6'd9;
  localparam logic [5:0] S_TLA   = 6'd10;
  localparam logic [5:0] S_TLB   = 6'd11;
  localparam logic [5:0] S_TLC   = 6'd12;
  localparam logic [5:0] S_P0    = 6'd13;
  localparam logic [5:0] S_P1    = 6'd14;
  localparam logic [5:0] S_P2    = 6'd15;
  localparam logic [5:0] S_P3    = 6'd16;
  localparam logic [5:0] S_P4    = 6'd17;
  localparam logic [5:0] S_P5    = 6'd18;
  localparam logic [5:0] S_R0    = 6'd19;
  localparam logic [5:0] S_R1    = 6'd20;
  localparam logic [5:0] S_R2    = 6'd21;
  localparam logic [5:0] S_R3    = 6'd22;
  localparam logic [5:0] S_EVAL  = 6'd23;
  localparam logic [5:0] S_EN0   = 6'd24;
  localparam logic [5:0] S_EN1   = 6'd25;
  localparam logic [5:0] S_ENL   = 6'd26;
  localparam logic [5:0] S_SQ0   = 6'd27;
  localparam logic [5:0] S_SQ1   = 6'd28;
  localparam logic [5:0] S_CB0   = 6'd29;
  localparam logic [5:0] S_CB1   = 6'd30;
  localparam logic [5:0] S_CB2   = 6'd31;
  localparam logic [5:0] S_CB3   = 6'd32;
  localparam logic [5:0] S_ROOTN = 6'd33;
  localparam logic [5:0] S_ENP   = 6'd34;
  localparam logic [5:0] S_ENG   = 6'd35;
  localparam logic [5:0] S_ENV   = 6'd36;
  localparam logic [5:0] S_ENO   = 6'd37;
  localparam logic [5:0] S_ENS   = 6'd38;
  localparam logic [5:0] S_DONE  = 6'd39;

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_GREY  = 3'd1;
  localparam logic [2:0] PH_HALF  = 3'd2;
  localparam logic [2:0] PH_BIS   = 3'd3;
  localparam logic [2:0] PH_FINAL = 3'd4;

  localparam logic [1:0] RP_Q2 = 2'd0;
  localparam logic [1:0] RP_Q4 = 2'd1;
  localparam logic [1:0] RP_Q3 = 2'd2;
  localparam logic [1:0] RP_Q6 = 2'd3;

  localparam logic ADDR_TOL = 1'b0;

  logic [5:0]          state_r;
  logic [11:0]         tol_r;
  logic [15:0]         hue_r;
  logic [15:0]         c_in_r;
  ogc_pkg::q_t         l_r, x_r, x2_r, t_r, ts_r, cs_r, sn_r;
  ogc_pkg::q_t         cur_c_r, a_r, b_r, p_r;
  ogc_pkg::q_t         cube_r [3];
  ogc_pkg::q_t         rgb_r [3];
  ogc_pkg::wide_t      acc_r, v_r, mres_r;
  logic [59:0]         mraw_r;
  logic [3:0]          idx_r;
  logic                neg_r;
  logic [1:0]          k_r;
  logic [2:0]          phase_r;
  logic                clip_r;
  logic [23:0]         c_fin_r, lo_r, hi_r;
  logic [STEP_W-1:0]   step_r;
  logic [24:0]         c_r;
  logic [63:0]         rn_r;
  logic [25:0]         root_r, cand_r, q4_r, q6_r;
  logic [4:0]          sbit_r;
  logic [1:0]          rp_r;
  logic [43:0]         t2_r;
  logic [59:0]         cubelo_r;
  logic [15:0]         chan_r [3];
  logic                out_valid_r;
  logic [15:0]         red_r, green_r, blue_r, cu_r;
  logic                wc_r;

  // shared multiplier with rounding of the Q24 product
  ogc_pkg::mop_t  ma, mb;
  logic [29:0]    ua, ub;
  logic [59:0]    prod;
  logic [35:0]    rnd;
  ogc_pkg::wide_t mres_nxt;

  assign ua = ma[29] ? 30'(-ma) : 30'(ma);
  assign ub = mb[29] ? 30'(-mb) : 30'(mb);
  assign prod = ua * ub;
  assign rnd = 36'((prod + 60'd8388608) >> 24);
  assign mres_nxt = (ma[29] ^ mb[29]) ? -ogc_pkg::wide_t'({2'b00, rnd})
                                      : ogc_pkg::wide_t'({2'b00, rnd});

  logic [25:0]    t_cand;
  logic [24:0]    rgb_clamp, v_clamp;
  ogc_pkg::q_t    rgb_k;
  ogc_pkg::wide_t mres_abs, quo_w, qs;
  logic [29:0]    quo;
  ogc_pkg::q_t    t_new, s_val;
  logic [66:0]    cube_v;
  logic           sq_ok, cb_ok;

  assign t_cand = root_r | (26'd1 << sbit_r);
  assign rgb_k = rgb_r[k_r];
  assign rgb_clamp = rgb_k[27] ? 25'd0
                   : (rgb_k > 28'sd16777216 ? 25'd16777216 : rgb_k[24:0]);
  assign v_clamp = v_r[37] ? 25'd0
                 : (v_r > ogc_pkg::Q_ONE ? 25'd16777216 : v_r[24:0]);
  assign mres_abs = mres_r[37] ? -mres_r : mres_r;
  assign quo = 30'(mraw_r >> ogc_pkg::ser_sh(idx_r));
  assign quo_w = ogc_pkg::wide_t'({8'b0, quo});
  assign qs = neg_r ? -quo_w : quo_w;
  assign t_new = ogc_pkg::q_t'(ogc_pkg::Q_ONE - qs);
  assign s_val = ogc_pkg::q_t'(mres_r);
  assign cube_v = {1'b0, mraw_r[43:0], 22'b0} + 67'(cubelo_r[43:0]);
  assign sq_ok = {4'b0, mraw_r} <= rn_r;
  assign cb_ok = cube_v <= {3'b0, rn_r};

  // gamut test with tolerance
  logic signed [29:0] tol_s, lo_b, hi_b;
  logic [2:0]         ch_ok;
  logic               gam_ok;

  assign tol_s = $signed({10'b0, tol_r, 8'b0});
  assign lo_b = -tol_s;
  assign hi_b = 30'sd16777216 + tol_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_ok[i] = (ogc_pkg::mop_t'(rgb_r[i]) >= lo_b) && (ogc_pkg::mop_t'(rgb_r[i]) <= hi_b);
    end
  end
  assign gam_ok = &ch_ok;

  // bisection
  logic [23:0] lo_n, hi_n;
  logic [24:0] bsum;

  assign lo_n = gam_ok ? cur_c_r[23:0] : lo_r;
  assign hi_n = gam_ok ? hi_r : cur_c_r[23:0];
  assign bsum = {1'b0, lo_n} + {1'b0, hi_n};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_SX0: begin
        ma = ogc_pkg::mop_t'({16'b0, hue_r[13:0]});
        mb = ogc_pkg::HALFPI;
      end
      S_SX2: begin
        ma = ogc_pkg::mop_t'(x_r);
        mb = ogc_pkg::mop_t'(x_r);
      end
      S_SER0: begin
        ma = ogc_pkg::mop_t'(x2_r);
        mb = ogc_pkg::mop_t'(t_r);
      end
      S_SER1: begin
        ma = ogc_pkg::mop_t'({1'b0, mres_abs[28:0]});
        mb = ogc_pkg::ser_rcp(idx_r);
      end
      S_SIN0: begin
        ma = ogc_pkg::mop_t'(x_r);
        mb = ogc_pkg::mop_t'(ts_r);
      end
      S_TLA: begin
        ma = ogc_pkg::mop_t'(cur_c_r);
        mb = ogc_pkg::mop_t'(cs_r);
      end
      S_TLB: begin
        ma = ogc_pkg::mop_t'(cur_c_r);
        mb = ogc_pkg::mop_t'(sn_r);
      end
      S_P0: begin
        ma = ogc_pkg::lab_coef(k_r, 1'b0);
        mb = ogc_pkg::mop_t'(a_r);
      end
      S_P1: begin
        ma = ogc_pkg::lab_coef(k_r, 1'b1);
        mb = ogc_pkg::mop_t'(b_r);
      end
      S_P3: begin
        ma = ogc_pkg::mop_t'(p_r);
        mb = ogc_pkg::mop_t'(p_r);
      end
      S_P4: begin
        ma = ogc_pkg::mop_t'(ogc_pkg::sat_q(mres_r));
        mb = ogc_pkg::mop_t'(p_r);
      end
      S_R0: begin
        ma = ogc_pkg::rgb_coef(k_r, 2'd0);
        mb = ogc_pkg::mop_t'(cube_r[0]);
      end
      S_R1: begin
        ma = ogc_pkg::rgb_coef(k_r, 2'd1);
        mb = ogc_pkg::mop_t'(cube_r[1]);
      end
      S_R2: begin
        ma = ogc_pkg::rgb_coef(k_r, 2'd2);
        mb = ogc_pkg::mop_t'(cube_r[2]);
      end
      S_EN1: begin
        ma = ogc_pkg::SLOPE;
        mb = ogc_pkg::mop_t'({5'b0, c_r});
      end
      S_SQ0, S_CB0: begin
        ma = ogc_pkg::mop_t'({4'b0, t_cand});
        mb = ogc_pkg::mop_t'({4'b0, t_cand});
      end
      S_CB1: begin
        ma = ogc_pkg::mop_t'({8'b0, mraw_r[21:0]});
        mb = ogc_pkg::mop_t'({4'b0, cand_r});
      end
      S_CB2: begin
        ma = ogc_pkg::mop_t'({8'b0, t2_r[43:22]});
        mb = ogc_pkg::mop_t'({4'b0, cand_r});
      end
      S_ENP: begin
        ma = ogc_pkg::mop_t'({4'b0, q4_r});
        mb = ogc_pkg::mop_t'({4'b0, q6_r});
      end
      S_ENG: begin
        ma = ogc_pkg::GAIN;
        mb = ogc_pkg::mop_t'(mres_r);
      end
      S_ENO: begin
        ma = ogc_pkg::mop_t'({5'b0, v_clamp});
        mb = ogc_pkg::mop_t'({13'b0, CHAN_MAX});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mres_r <= mres_nxt;
    mraw_r <= prod;
  end

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_TOL) ? {20'b0, tol_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_TOL) begin
      tol_r <= pwdata[11:0];
    end
  end

  assign in_if.ready = (state_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            l_r <= ogc_pkg::q_t'({3'b0, in_if.lightness, 9'b0});
            c_in_r <= in_if.chroma;
            hue_r <= in_if.hue;
            state_r <= S_SX0;
          end
        end
        S_SX0: state_r <= S_SX1;
        S_SX1: begin
          x_r <= ogc_pkg::q_t'((mraw_r + 60'd8192) >> 14);
          state_r <= S_SX2;
        end
        S_SX2: state_r <= S_SX3;
        S_SX3: begin
          x2_r <= ogc_pkg::q_t'(mres_r);
          t_r <= ogc_pkg::q_t'(ogc_pkg::Q_ONE);
          idx_r <= '0;
          state_r <= S_SER0;
        end
        S_SER0: state_r <= S_SER1;
        S_SER1: begin
          neg_r <= mres_r[37];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (idx_r == ogc_pkg::SIN_LAST) begin
            ts_r <= t_new;
            t_r <= ogc_pkg::q_t'(ogc_pkg::Q_ONE);
          end else begin
            t_r <= t_new;
          end
          idx_r <= idx_r + 4'd1;
          state_r <= (idx_r == ogc_pkg::COS_LAST) ? S_SIN0 : S_SER0;
        end
        S_SIN0: state_r <= S_SIN1;
        S_SIN1: begin
          unique case (hue_r[15:14])
            2'd0: begin
              cs_r <= t_r;
              sn_r <= s_val;
            end
            2'd1: begin
              cs_r <= -s_val;
              sn_r <= t_r;
            end
            2'd2: begin
              cs_r <= -t_r;
              sn_r <= -s_val;
            end
            default: begin
              cs_r <= s_val;
              sn_r <= -t_r;
            end
          endcase
          clip_r <= 1'b0;
          cur_c_r <= ogc_pkg::q_t'({4'b0, c_in_r, 8'b0});
          c_fin_r <= {c_in_r, 8'b0};
          phase_r <= (c_in_r == 16'd0) ? PH_FINAL : PH_FIRST;
          state_r <= S_TLA;
        end
        S_TLA: state_r <= S_TLB;
        S_TLB: begin
          a_r <= ogc_pkg::sat_q(mres_r);
          state_r <= S_TLC;
        end
        S_TLC: begin
          b_r <= ogc_pkg::sat_q(mres_r);
          k_r <= '0;
          state_r <= S_P0;
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          acc_r <= ogc_pkg::wide_t'(l_r) + mres_r;
          state_r <= S_P2;
        end
        S_P2: begin
          p_r <= ogc_pkg::sat_q(acc_r + mres_r);
          state_r <= S_P3;
        end
        S_P3: state_r <= S_P4;
        S_P4: state_r <= S_P5;
        S_P5: begin
          cube_r[k_r] <= ogc_pkg::sat_q(mres_r);
          if (k_r == 2'd2) begin
            k_r <= '0;
            state_r <= S_R0;
          end else begin
            k_r <= k_r + 2'd1;
            state_r <= S_P0;
          end
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          acc_r <= mres_r;
          state_r <= S_R2;
        end
        S_R2: begin
          acc_r <= acc_r + mres_r;
          state_r <= S_R3;
        end
        S_R3: begin
          rgb_r[k_r] <= ogc_pkg::sat_q(acc_r + mres_r);
          if (k_r == 2'd2) begin
            k_r <= '0;
            state_r <= S_EVAL;
          end else begin
            k_r <= k_r + 2'd1;
            state_r <= S_R0;
          end
        end
        S_EVAL: begin
          unique case (phase_r)
            PH_FIRST: begin
              if (gam_ok) begin
                state_r <= S_EN0;
              end else begin
                clip_r <= 1'b1;
                cur_c_r <= '0;
                phase_r <= PH_GREY;
                state_r <= S_TLA;
              end
            end
            PH_GREY: begin
              if (!gam_ok) begin
                c_fin_r <= '0;
                state_r <= S_EN0;
              end else begin
                cur_c_r <= ogc_pkg::q_t'(ogc_pkg::Q_HALF);
                phase_r <= PH_HALF;
                state_r <= S_TLA;
              end
            end
            PH_HALF: begin
              if (gam_ok) begin
                c_fin_r <= 24'h800000;
                state_r <= S_EN0;
              end else begin
                lo_r <= '0;
                hi_r <= 24'h800000;
                step_r <= '0;
                cur_c_r <= ogc_pkg::q_t'(ogc_pkg::Q_HALF >>> 1);
                phase_r <= PH_BIS;
                state_r <= S_TLA;
              end
            end
            PH_BIS: begin
              lo_r <= lo_n;
              hi_r <= hi_n;
              step_r <= step_r + 1'b1;
              if (step_r == STEP_W'(SEARCH_STEPS - 1)) begin
                c_fin_r <= lo_n;
                cur_c_r <= ogc_pkg::q_t'({4'b0, lo_n});
                phase_r <= PH_FINAL;
              end else begin
                cur_c_r <= ogc_pkg::q_t'({4'b0, bsum[24:1]});
              end
              state_r <= S_TLA;
            end
            PH_FINAL: state_r <= S_EN0;
            default:  state_r <= S_IDLE;
          endcase
        end
        S_EN0: begin
          c_r <= rgb_clamp;
          state_r <= S_EN1;
        end
        S_EN1: begin
          if (c_r <= ogc_pkg::KNEE) begin
            state_r <= S_ENL;
          end else begin
            rp_r <= RP_Q2;
            rn_r <= 64'({c_r, 24'b0});
            root_r <= '0;
            sbit_r <= 5'd25;
            state_r <= S_SQ0;
          end
        end
        S_ENL: begin
          v_r <= mres_r;
          state_r <= S_ENO;
        end
        S_SQ0: begin
          cand_r <= t_cand;
          state_r <= S_SQ1;
        end
        S_SQ1: begin
          if (sq_ok) begin
            root_r <= cand_r;
          end
          if (sbit_r == 5'd0) begin
            state_r <= S_ROOTN;
          end else begin
            sbit_r <= sbit_r - 5'd1;
            state_r <= S_SQ0;
          end
        end
        S_CB0: begin
          cand_r <= t_cand;
          state_r <= S_CB1;
        end
        S_CB1: begin
          t2_r <= mraw_r[43:0];
          state_r <= S_CB2;
        end
        S_CB2: begin
          cubelo_r <= mraw_r;
          state_r <= S_CB3;
        end
        S_CB3: begin
          if (cb_ok) begin
            root_r <= cand_r;
          end
          if (sbit_r == 5'd0) begin
            state_r <= S_ROOTN;
          end else begin
            sbit_r <= sbit_r - 5'd1;
            state_r <= S_CB0;
          end
        end
        S_ROOTN: begin
          root_r <= '0;
          unique case (rp_r)
            RP_Q2: begin
              rn_r <= 64'({root_r, 24'b0});
              rp_r <= RP_Q4;
              sbit_r <= 5'd25;
              state_r <= S_SQ0;
            end
            RP_Q4: begin
              q4_r <= root_r;
              rn_r <= 64'({c_r, 39'b0});
              rp_r <= RP_Q3;
              sbit_r <= 5'd21;
              state_r <= S_CB0;
            end
            RP_Q3: begin
              rn_r <= 64'({root_r, 27'b0});
              rp_r <= RP_Q6;
              sbit_r <= 5'd25;
              state_r <= S_SQ0;
            end
            default: begin
              q6_r <= root_r;
              state_r <= S_ENP;
            end
          endcase
        end
        S_ENP: state_r <= S_ENG;
        S_ENG: state_r <= S_ENV;
        S_ENV: begin
          v_r <= mres_r - ogc_pkg::OFFS;
          state_r <= S_ENO;
        end
        S_ENO: state_r <= S_ENS;
        S_ENS: begin
          chan_r[k_r] <= mres_r[15:0];
          if (k_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 2'd1;
            state_r <= S_EN0;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            red_r <= chan_r[0];
            green_r <= chan_r[1];
            blue_r <= chan_r[2];
            cu_r <= c_fin_r[23:8];
            wc_r <= clip_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_if.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.red = red_r;
  assign out_if.green = green_r;
  assign out_if.blue = blue_r;
  assign out_if.chroma_used = cu_r;
  assign out_if.was_clipped = wc_r;

endmodule
